[rtl/lfukv_pkg.sv]
// Package for the LFU/FIFO key-value cache: sizes, register indexes,
// entry layout and sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lfukv_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;
  localparam int COUNT_BITS  = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CH_W        = IDX_W + 2;
  localparam int CAP_W       = 4;
  localparam int CFG_W       = 4;

  localparam logic REG_POLICY   = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  localparam logic CMD_FIND   = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LFU  = 1'b1;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0] cnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK,
    S_MISS,
    S_EV,
    S_EV_LD,
    S_DN_RD,
    S_DN_L,
    S_DN_R,
    S_DN_DEC,
    S_UP,
    S_UP_CMP,
    S_FV,
    S_FS,
    S_FW,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[rtl/lfu_fifo_key_value_cache_core.sv]
// Top level of the LFU/FIFO key-value cache: sequencer around one entry RAM.
// Depends on lfukv_pkg and lfukv_ram.
`timescale 1ns / 1ps
`default_nettype none
// A request is taken when start is high and busy is low. One result follows,
// valid for the single cycle in which done is high; the receiver cannot stall.
// Every request first walks the stored entries, if there are any, with one RAM
// read per cycle; a miss then passes through the miss state, and every
// request ends in the done state.
// An LFU find hit then sifts down, reading the left child, then the right
// child if there is one, then comparing and writing back at each level.
// An LFU insert checks for eviction; each eviction loads the last entry into
// the root and sifts it down. The new entry then sifts up a level at a time.
// A FIFO insert sets the fill, shifts each entry up one slot with a read and
// a write, then writes the new entry to slot 0.
// The pace is set by the RAM's single read port and its registered read.
module lfu_fifo_key_value_cache_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            cmd,
  input  wire logic [lfukv_pkg::KEY_BITS-1:0]   key_tag,
  input  wire logic [lfukv_pkg::VALUE_BITS-1:0] data_value,
  output logic                                 done,
  output logic                                 hit,
  output logic [lfukv_pkg::VALUE_BITS-1:0]      found_value,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_addr,
  input  wire logic [lfukv_pkg::CFG_W-1:0]      cfg_wdata
);
  import lfukv_pkg::*;

  state_t                state, state_next;
  logic                  policy;
  logic [CAP_W-1:0]      capacity;
  logic [CNT_W-1:0]      count;
  logic                  req_cmd;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_val;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      pos;
  entry_t                mv, ld, rd;
  logic                  r_ok;
  logic                  after_ev;
  logic                  hit_r;
  logic [VALUE_BITS-1:0] value_r;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  entry_t                ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0]    ram_q;

  logic [CNT_W-1:0]      cap;
  logic [CH_W-1:0]       lc, rc, cnt_ext;
  logic                  key_match, lk_last;
  logic [IDX_W-1:0]      m_pos;
  entry_t                m_ent;
  logic [CNT_W-1:0]      fifo_cnt;

  assign ram_rdata = entry_t'(ram_q);

  lfukv_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Effective capacity clamped to 1..MAX_ENTRIES
  always_comb begin
    if (capacity == '0) begin
      cap = CNT_W'(1);
    end else if (CNT_W'(capacity) > CNT_W'(MAX_ENTRIES) || capacity > CAP_W'(MAX_ENTRIES)) begin
      cap = CNT_W'(MAX_ENTRIES);
    end else begin
      cap = CNT_W'(capacity);
    end
  end

  assign lc        = CH_W'({pos, 1'b1});
  assign rc        = lc + CH_W'(1);
  assign cnt_ext   = CH_W'(count);
  assign key_match = (ram_rdata.key == req_key);
  assign lk_last   = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign fifo_cnt  = (count >= cap) ? cap - CNT_W'(1) : count;

  // Smallest of moving entry and its children; ties go to the child
  always_comb begin
    m_pos = pos;
    m_ent = mv;
    if (!(mv.cnt < ld.cnt)) begin
      m_pos = IDX_W'(lc);
      m_ent = ld;
    end
    if (r_ok && !(m_ent.cnt < rd.cnt)) begin
      m_pos = IDX_W'(rc);
      m_ent = rd;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      policy   <= POLICY_LFU;
      capacity <= CAP_W'(5);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_POLICY:   policy   <= cfg_wdata[0];
        REG_CAPACITY: capacity <= cfg_wdata[CAP_W-1:0];
        default:      ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and RAM control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = pos;
    ram_wdata  = mv;
    ram_raddr  = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (count == '0) ? S_MISS : S_LK;
        end
      end
      S_LK: begin
        ram_raddr = idx + IDX_W'(1);
        if (key_match) begin
          if (req_cmd == CMD_INSERT) begin
            ram_we     = 1'b1;
            ram_waddr  = idx;
            ram_wdata  = ram_rdata;
            ram_wdata.value = req_val;
            state_next = S_DONE;
          end else if (policy == POLICY_LFU) begin
            state_next = S_DN_RD;
          end else begin
            state_next = S_DONE;
          end
        end else if (lk_last) begin
          state_next = S_MISS;
        end
      end
      S_MISS: begin
        if (req_cmd == CMD_FIND) begin
          state_next = S_DONE;
        end else begin
          state_next = (policy == POLICY_LFU) ? S_EV : S_FV;
        end
      end
      S_EV: begin
        ram_raddr = IDX_W'(count - CNT_W'(1));
        if (count >= cap && count != '0) begin
          state_next = (count != CNT_W'(1)) ? S_EV_LD : S_EV;
        end else begin
          state_next = S_UP;
        end
      end
      S_EV_LD: state_next = S_DN_RD;
      S_DN_RD: begin
        ram_raddr = IDX_W'(lc);
        if (lc >= cnt_ext) begin
          ram_we     = 1'b1;
          state_next = after_ev ? S_EV : S_DONE;
        end else begin
          state_next = S_DN_L;
        end
      end
      S_DN_L: begin
        ram_raddr  = IDX_W'(rc);
        state_next = (rc < cnt_ext) ? S_DN_R : S_DN_DEC;
      end
      S_DN_R: state_next = S_DN_DEC;
      S_DN_DEC: begin
        ram_we = 1'b1;
        if (m_pos == pos) begin
          state_next = after_ev ? S_EV : S_DONE;
        end else begin
          ram_wdata  = m_ent;
          state_next = S_DN_RD;
        end
      end
      S_UP: begin
        ram_raddr = (pos - IDX_W'(1)) >> 1;
        if (pos == '0) begin
          ram_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata.cnt > mv.cnt) begin
          ram_wdata  = ram_rdata;
          state_next = S_UP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FV: state_next = S_FS;
      S_FS: begin
        ram_raddr = idx - IDX_W'(1);
        if (idx == '0) begin
          ram_we     = 1'b1;
          ram_waddr  = '0;
          ram_wdata  = '{key: req_key, value: req_val, cnt: COUNT_BITS'(1)};
          state_next = S_DONE;
        end else begin
          state_next = S_FW;
        end
      end
      S_FW: begin
        ram_we     = 1'b1;
        ram_waddr  = idx;
        ram_wdata  = ram_rdata;
        state_next = S_FS;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (state)
        S_EV: begin
          if (count >= cap && count != '0) begin
            count <= count - CNT_W'(1);
          end else begin
            count <= count + CNT_W'(1);
          end
        end
        S_FV: count <= fifo_cnt;
        S_FS: begin
          if (idx == '0) begin
            count <= count + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        req_cmd  <= cmd;
        req_key  <= key_tag;
        req_val  <= data_value;
        idx      <= '0;
        after_ev <= 1'b0;
        hit_r    <= 1'b0;
        value_r  <= '0;
      end
      S_LK: begin
        idx <= idx + IDX_W'(1);
        if (key_match && req_cmd == CMD_FIND) begin
          hit_r   <= 1'b1;
          value_r <= ram_rdata.value;
          pos     <= idx;
          // Count saturates at all ones
          mv      <= '{key: ram_rdata.key, value: ram_rdata.value,
                       cnt: (ram_rdata.cnt != '1) ? ram_rdata.cnt + COUNT_BITS'(1)
                                                 : ram_rdata.cnt};
        end
      end
      S_EV: begin
        after_ev <= 1'b1;
        if (!(count >= cap && count != '0)) begin
          mv  <= '{key: req_key, value: req_val, cnt: COUNT_BITS'(1)};
          pos <= IDX_W'(count);
        end
      end
      S_EV_LD: begin
        mv  <= ram_rdata;
        pos <= '0;
      end
      S_DN_L: begin
        ld   <= ram_rdata;
        r_ok <= (rc < cnt_ext);
      end
      S_DN_R: rd <= ram_rdata;
      S_DN_DEC: pos <= m_pos;
      S_UP_CMP: begin
        if (ram_rdata.cnt > mv.cnt) begin
          pos <= (pos - IDX_W'(1)) >> 1;
        end
      end
      S_FV: idx <= IDX_W'(fifo_cnt);
      S_FW: idx <= idx - IDX_W'(1);
      default: ;
    endcase
  end

  assign busy        = (state != S_IDLE);
  assign done        = (state == S_DONE);
  assign hit         = hit_r;
  assign found_value = value_r;

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES)) else $error("entry count above depth");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result outside a request");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("still busy after result");
  a_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (found_value == '0)) else $error("miss with value");

endmodule
`default_nettype wire

[rtl/lfukv_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lfukv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[tb/lfu_fifo_key_value_cache_core_tb.sv]
// Self-checking testbench for the LFU/FIFO key-value cache core.
// Drives find/insert transfers and checks each result against a local cache predictor.
// Depends on lfukv_pkg and the lfu_fifo_key_value_cache_core RTL.
`timescale 1ns / 1ps
module lfu_fifo_key_value_cache_core_tb;
  import lfukv_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int DRAIN_CYCLES = 64;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic cmd;
  logic [KEY_BITS-1:0] key_tag;
  logic [VALUE_BITS-1:0] data_value;
  logic done;
  logic hit;
  logic [VALUE_BITS-1:0] found_value;
  logic cfg_we;
  logic cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  lfu_fifo_key_value_cache_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .key_tag(key_tag), .data_value(data_value), .done(done), .hit(hit),
    .found_value(found_value), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  typedef struct {
    logic hit;
    logic [VALUE_BITS-1:0] value;
  } lookup_result_t;

  // Predictor copy of cache state
  logic [KEY_BITS-1:0] cache_key [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] cache_value [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] cache_uses [MAX_ENTRIES];
  int unsigned cache_fill;
  logic cache_policy;
  logic [CAP_W-1:0] cache_capacity;

  lookup_result_t pending_results[$];
  int errors;
  int results_seen;
  int hits_seen;
  int evict_inserts;
  longint cycle_count;
  logic [KEY_BITS-1:0] key_pool [16];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_error(input string what, input logic [63:0] got,
                              input logic [63:0] want);
    errors++;
    $display("ERROR @%0t: %s got %h expected %h", $time, what, got, want);
  endtask

  // Result monitor: one transfer per done pulse
  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (!rst && done) begin
      results_seen++;
      if (hit) hits_seen++;
      if (pending_results.size() == 0) begin
        report_error("unexpected result", {hit, found_value}, 0);
      end else begin
        exp_r = pending_results.pop_front();
        if (hit !== exp_r.hit) report_error("hit", hit, exp_r.hit);
        if (found_value !== exp_r.value) report_error("found_value", found_value, exp_r.value);
      end
    end
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [KEY_BITS-1:0] k;
    logic [VALUE_BITS-1:0] v;
    logic [COUNT_BITS-1:0] c;
    k = cache_key[a]; v = cache_value[a]; c = cache_uses[a];
    cache_key[a] = cache_key[b]; cache_value[a] = cache_value[b];
    cache_uses[a] = cache_uses[b];
    cache_key[b] = k; cache_value[b] = v; cache_uses[b] = c;
  endfunction

  // Ties move down, right child preferred over left
  function automatic void heap_sink(int unsigned pos);
    int unsigned l, r, m;
    while (pos < cache_fill) begin
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      m = pos;
      if (l < cache_fill) m = (cache_uses[pos] < cache_uses[l]) ? pos : l;
      if (r < cache_fill) m = (cache_uses[m] < cache_uses[r]) ? m : r;
      if (m == pos) break;
      swap_slots(m, pos);
      pos = m;
    end
  endfunction

  function automatic void heap_rise(int unsigned pos);
    int unsigned p;
    while (pos > 0 && pos < cache_fill) begin
      p = (pos - 1) / 2;
      if (!(cache_uses[p] > cache_uses[pos])) break;
      swap_slots(p, pos);
      pos = p;
    end
  endfunction

  function automatic lookup_result_t cache_access(logic op, logic [KEY_BITS-1:0] k,
                                                  logic [VALUE_BITS-1:0] v);
    lookup_result_t r;
    int slot;
    int unsigned lim;
    r.hit = 1'b0;
    r.value = '0;
    slot = -1;
    lim = (cache_capacity == 0) ? 1 : (cache_capacity > MAX_ENTRIES) ? MAX_ENTRIES
                                                                     : cache_capacity;
    for (int i = 0; i < cache_fill; i++)
      if (slot < 0 && cache_key[i] == k) slot = i;
    if (op == CMD_FIND) begin
      if (slot >= 0) begin
        r.hit = 1'b1;
        r.value = cache_value[slot];
        if (cache_policy == POLICY_LFU) begin
          if (cache_uses[slot] != '1) cache_uses[slot]++;
          heap_sink(slot);
        end
      end
      return r;
    end
    if (slot >= 0) begin
      cache_value[slot] = v;
      return r;
    end
    if (cache_fill >= lim) evict_inserts++;
    if (cache_policy == POLICY_LFU) begin
      while (cache_fill >= lim && cache_fill > 0) begin
        cache_fill--;
        if (cache_fill > 0) begin
          cache_key[0] = cache_key[cache_fill];
          cache_value[0] = cache_value[cache_fill];
          cache_uses[0] = cache_uses[cache_fill];
          heap_sink(0);
        end
      end
      cache_key[cache_fill] = k;
      cache_value[cache_fill] = v;
      cache_uses[cache_fill] = 1;
      cache_fill++;
      heap_rise(cache_fill - 1);
    end else begin
      while (cache_fill >= lim && cache_fill > 0) cache_fill--;
      for (int i = cache_fill; i > 0; i--) begin
        cache_key[i] = cache_key[i-1];
        cache_value[i] = cache_value[i-1];
        cache_uses[i] = cache_uses[i-1];
      end
      cache_key[0] = k;
      cache_value[0] = v;
      cache_uses[0] = 1;
      cache_fill++;
    end
    return r;
  endfunction

  function automatic bit key_present(logic [KEY_BITS-1:0] k);
    for (int i = 0; i < cache_fill; i++)
      if (cache_key[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  // One request transfer; typed expectation used when check_typed is set
  task automatic send_request(logic op, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v,
                              bit check_typed = 0, logic typed_hit = 0,
                              logic [VALUE_BITS-1:0] typed_value = 0);
    lookup_result_t r;
    start <= 1'b1;
    cmd <= op;
    key_tag <= k;
    data_value <= v;
    do @(posedge clk); while (busy);
    r = cache_access(op, k, v);
    if (check_typed && (r.hit !== typed_hit || r.value !== typed_value))
      report_error("predictor vs table", {r.hit, r.value}, {typed_hit, typed_value});
    pending_results.push_back(check_typed ? lookup_result_t'{typed_hit, typed_value} : r);
  endtask

  task automatic drop_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_POLICY) cache_policy = val[0];
    else cache_capacity = val;
  endtask

  // Directed table
  typedef struct {
    logic op;
    logic [KEY_BITS-1:0] k;
    logic [VALUE_BITS-1:0] v;
    bit typed;
    logic exp_hit;
    logic [VALUE_BITS-1:0] exp_value;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    '{CMD_FIND,   32'h0000_0000, 32'h0,          1, 1'b0, 32'h0},
    '{CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF,  1, 1'b0, 32'h0},
    '{CMD_FIND,   32'h0000_0000, 32'h1234_5678,  1, 1'b1, 32'hFFFF_FFFF},
    '{CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000,  1, 1'b0, 32'h0},
    '{CMD_FIND,   32'hFFFF_FFFF, 32'h0,          1, 1'b1, 32'h0},
    '{CMD_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A,  1, 1'b0, 32'h0},
    '{CMD_FIND,   32'hFFFF_FFFF, 32'h0,          1, 1'b1, 32'hA5A5_5A5A},
    '{CMD_INSERT, 32'h5555_5555, 32'h1111_1111,  1, 1'b0, 32'h0},
    '{CMD_INSERT, 32'hAAAA_AAAA, 32'h2222_2222,  1, 1'b0, 32'h0},
    '{CMD_INSERT, 32'h0000_0001, 32'h3333_3333,  1, 1'b0, 32'h0},
    '{CMD_FIND,   32'h0000_0001, 32'h0,          0, 1'b0, 32'h0},
    '{CMD_FIND,   32'h5555_5555, 32'h0,          0, 1'b0, 32'h0},
    '{CMD_INSERT, 32'h8000_0000, 32'h4444_4444,  0, 1'b0, 32'h0},
    '{CMD_FIND,   32'h0000_0000, 32'h0,          0, 1'b0, 32'h0},
    '{CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0001,  0, 1'b0, 32'h0},
    '{CMD_FIND,   32'h7FFF_FFFF, 32'h0,          0, 1'b0, 32'h0},
    '{CMD_FIND,   32'hDEAD_BEEF, 32'h0,          1, 1'b0, 32'h0}
  };

  task automatic run_random(int count, bit with_gaps);
    logic op;
    logic [KEY_BITS-1:0] k;
    logic [VALUE_BITS-1:0] v;
    for (int n = 0; n < count; n++) begin
      // Mostly pool keys so hits and counts build up; some fully random keys
      if ($urandom_range(0, 9) == 0) k = $urandom();
      else k = key_pool[$urandom_range(0, 15)];
      v = $urandom();
      op = $urandom_range(0, 1);
      // Insert normally follows a miss; rarely overwrite a present key
      if (op == CMD_INSERT && key_present(k) && $urandom_range(0, 7) != 0) op = CMD_FIND;
      send_request(op, k, v);
      if (with_gaps && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    hits_seen = 0;
    evict_inserts = 0;
    cache_fill = 0;
    cache_policy = POLICY_LFU;
    cache_capacity = 5;
    for (int i = 0; i < 16; i++) key_pool[i] = (i < 2) ? (i ? '1 : '0) : $urandom();
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= CMD_FIND;
    key_tag <= '0;
    data_value <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_POLICY;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings
    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].k, directed_rows[i].v,
                   directed_rows[i].typed, directed_rows[i].exp_hit,
                   directed_rows[i].exp_value);
    wait_drained();

    // Capacity lowered below fill
    write_reg(REG_CAPACITY, 4'd2);
    send_request(CMD_INSERT, 32'h0BAD_F00D, 32'h0F0F_0F0F, 1, 1'b0, 32'h0);
    send_request(CMD_FIND, 32'h0BAD_F00D, 32'h0, 1, 1'b1, 32'h0F0F_0F0F);
    wait_drained();

    // Policy switch with entries in place, then capacities at the extremes and out of range
    write_reg(REG_POLICY, POLICY_FIFO);
    write_reg(REG_CAPACITY, 4'd0);
    run_random(20, 1);
    wait_drained();
    write_reg(REG_CAPACITY, 4'd15);
    run_random(250, 1);
    wait_drained();
    write_reg(REG_POLICY, POLICY_LFU);
    write_reg(REG_CAPACITY, 4'd8);
    run_random(400, 1);
    wait_drained();
    write_reg(REG_CAPACITY, 4'd1);
    run_random(150, 1);
    wait_drained();
    write_reg(REG_CAPACITY, 4'd3);
    run_random(350, 1);
    wait_drained();
    write_reg(REG_POLICY, POLICY_FIFO);
    write_reg(REG_CAPACITY, 4'd8);
    run_random(350, 1);
    wait_drained();
    // Final stretch back-to-back, no gaps
    write_reg(REG_POLICY, POLICY_LFU);
    write_reg(REG_CAPACITY, 4'd6);
    run_random(450, 0);
    wait_drained();

    $display("covered %0d results (%0d hits, %0d evicting inserts) over both policies",
             results_seen, hits_seen, evict_inserts);
    $display("capacities 0, 1, 2, 3, 6, 8 and 15 exercised, with a policy switch on a full cache");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[lfu_fifo_key_value_cache_core.f]
rtl/lfukv_pkg.sv
rtl/lfukv_ram.sv
rtl/lfu_fifo_key_value_cache_core.sv
tb/lfu_fifo_key_value_cache_core_tb.sv
